// ===== rtl/dmsl_pkg.sv =====
// Shared types, widths and helper functions for the damped motion step block.
// No dependencies; used by every other file of the block.
package dmsl_pkg;

  localparam int VW        = 32;
  localparam int TW        = 8;
  localparam int RW        = VW - 1;
  localparam int FDW       = RW + TW;
  localparam int PW        = VW + TW;
  localparam int SW        = VW + TW + 2;
  localparam int CW        = $clog2(VW);
  localparam int POS_SHIFT = 8;

  typedef logic signed [VW-1:0] vec_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_MUL_AX,
    CMD_ADD_VX,
    CMD_MUL_AY,
    CMD_ADD_VY,
    CMD_MUL_FD,
    CMD_SAVE_FD,
    CMD_SQ_X,
    CMD_SQ_Y,
    CMD_NORM,
    CMD_LIM_SQ,
    CMD_STOP,
    CMD_SET_CAP,
    CMD_SQRT_GO,
    CMD_SAVE_M,
    CMD_DMUL_X,
    CMD_DMUL_Y,
    CMD_DIV_GO,
    CMD_WR_X,
    CMD_WR_Y,
    CMD_MUL_PX,
    CMD_ADD_PX,
    CMD_MUL_PY,
    CMD_ADD_PY,
    CMD_RESULT
  } cmd_e;

  typedef enum logic [1:0] {
    PH_FRIC,
    PH_SPEED,
    PH_ACCEL
  } phase_e;

  typedef enum logic {
    IT_SQRT,
    IT_DIV
  } iter_mode_e;

  typedef enum logic [1:0] {
    REG_MAX_SPEED,
    REG_MAX_ACCEL,
    REG_FRICTION
  } reg_idx_e;

  typedef struct packed {
    cmd_e   op;
    phase_e phase;
  } dp_cmd_t;

  typedef struct packed {
    logic gt;
    logic fd_hi;
    logic iter_done;
  } dp_stat_t;

  function automatic logic [VW-1:0] mag(input vec_t v);
    logic [VW-1:0] u;
    u = v;
    return v[VW-1] ? VW'(~u + 1'b1) : u;
  endfunction

  function automatic vec_t with_sign(input logic neg, input logic [VW-1:0] m);
    return neg ? vec_t'(~m + 1'b1) : vec_t'(m);
  endfunction

  function automatic vec_t sat(input logic signed [SW-1:0] s);
    logic all1;
    logic all0;
    all1 = &s[SW-1:VW-1];
    all0 = ~(|s[SW-1:VW-1]);
    if (all1 || all0) begin
      return vec_t'(s[VW-1:0]);
    end else if (s[SW-1]) begin
      return vec_t'({1'b1, {(VW-1){1'b0}}});
    end
    return vec_t'({1'b0, {(VW-1){1'b1}}});
  endfunction

endpackage

// ===== rtl/dmsl_iter.sv =====
// Shared bit-serial unit: integer square root of a double-width word and
// unsigned division of a double-width word by a single-width divisor.
// Depends on dmsl_pkg.
module dmsl_iter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  dmsl_pkg::iter_mode_e       mode_i,
  input  logic [2*dmsl_pkg::VW-1:0]  src_i,
  input  logic [dmsl_pkg::VW-1:0]    den_i,
  output logic                       done_o,
  output logic [dmsl_pkg::VW-1:0]    res_o
);

  localparam int VW = dmsl_pkg::VW;

  logic                   busy_q;
  logic                   done_q;
  logic [dmsl_pkg::CW-1:0] cnt_q;
  dmsl_pkg::iter_mode_e   mode_q;
  logic [VW+1:0]          rem_q;
  logic [2*VW-1:0]        src_q;
  logic [VW-1:0]          res_q;
  logic [VW-1:0]          den_q;

  logic [VW+3:0] sq_cat;
  logic [VW+3:0] sq_trial;
  logic          sq_ge;
  logic [VW:0]   dv_cat;
  logic          dv_ge;

  always_comb begin
    sq_cat   = {rem_q, src_q[2*VW-1 -: 2]};
    sq_trial = {2'b00, res_q, 2'b01};
    sq_ge    = sq_cat >= sq_trial;
    dv_cat   = {rem_q[VW-1:0], src_q[2*VW-1]};
    dv_ge    = dv_cat >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= dmsl_pkg::IT_SQRT;
      rem_q  <= '0;
      src_q  <= '0;
      res_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        mode_q <= mode_i;
        den_q  <= den_i;
        res_q  <= '0;
        if (mode_i == dmsl_pkg::IT_SQRT) begin
          rem_q <= '0;
          src_q <= src_i;
        end else begin
          rem_q <= {2'b00, src_i[2*VW-1:VW]};
          src_q <= {src_i[VW-1:0], {VW{1'b0}}};
        end
      end else if (busy_q) begin
        if (mode_q == dmsl_pkg::IT_SQRT) begin
          rem_q <= sq_ge ? (VW+2)'(sq_cat - sq_trial) : sq_cat[VW+1:0];
          res_q <= {res_q[VW-2:0], sq_ge};
          src_q <= {src_q[2*VW-3:0], 2'b00};
        end else begin
          rem_q <= {1'b0, (dv_ge ? VW'(dv_cat - {1'b0, den_q}) : dv_cat[VW-1:0]), 1'b0} >> 1;
          res_q <= {res_q[VW-2:0], dv_ge};
          src_q <= {src_q[2*VW-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == dmsl_pkg::CW'(VW-1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/dmsl_dp.sv =====
// Datapath: state vectors, limit registers, shared multiplier and the
// sqrt/divide unit, driven one command per cycle. Depends on dmsl_pkg, dmsl_iter.
module dmsl_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [dmsl_pkg::RW-1:0]  cfg_data_i,
  input  logic                     req_type_i,
  input  logic                     accel_load_i,
  input  dmsl_pkg::vec_t           vec_x_i,
  input  dmsl_pkg::vec_t           vec_y_i,
  input  logic [dmsl_pkg::TW-1:0]  delta_ms_i,
  input  dmsl_pkg::dp_cmd_t        cmd_i,
  output dmsl_pkg::dp_stat_t       stat_o,
  output dmsl_pkg::vec_t           pos_x_out_o,
  output dmsl_pkg::vec_t           pos_y_out_o,
  output dmsl_pkg::vec_t           vel_x_out_o,
  output dmsl_pkg::vec_t           vel_y_out_o,
  output logic                     stopped_o,
  output logic                     speed_capped_o
);

  localparam int VW = dmsl_pkg::VW;
  localparam int TW = dmsl_pkg::TW;
  localparam int RW = dmsl_pkg::RW;
  localparam int SW = dmsl_pkg::SW;
  localparam int PW = dmsl_pkg::PW;

  dmsl_pkg::vec_t px_q, py_q, vx_q, vy_q, ax_q, ay_q;
  logic [RW-1:0]  max_speed_q, max_accel_q, fric_q;
  logic [TW-1:0]  dt_q;
  logic [dmsl_pkg::FDW-1:0] fd_q;
  logic [2*VW-1:0] mul_q;
  logic [2*VW-1:0] acc_q;
  logic [VW-1:0]  m_q;
  logic [VW-1:0]  num_q;
  logic           stopped_q, capped_q;
  dmsl_pkg::vec_t out_px_q, out_py_q, out_vx_q, out_vy_q;
  logic           out_stop_q, out_cap_q;

  dmsl_pkg::vec_t tx, ty;
  logic [VW-1:0]  lim;
  logic [VW-1:0]  mul_a, mul_b;
  logic [VW-1:0]  iter_res;
  logic           iter_done;
  logic           iter_go;
  dmsl_pkg::iter_mode_e iter_mode;
  logic signed [SW-1:0] step_ext;
  logic [PW:0]    pos_round;
  logic signed [SW-1:0] pos_ext;

  always_comb begin
    if (cmd_i.phase == dmsl_pkg::PH_ACCEL) begin
      tx = ax_q;
      ty = ay_q;
    end else begin
      tx = vx_q;
      ty = vy_q;
    end
    case (cmd_i.phase)
      dmsl_pkg::PH_FRIC:  lim = fd_q[VW-1:0];
      dmsl_pkg::PH_SPEED: lim = {1'b0, max_speed_q};
      default:            lim = {1'b0, max_accel_q};
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      dmsl_pkg::CMD_MUL_AX: begin mul_a = dmsl_pkg::mag(ax_q); mul_b = VW'(dt_q); end
      dmsl_pkg::CMD_MUL_AY: begin mul_a = dmsl_pkg::mag(ay_q); mul_b = VW'(dt_q); end
      dmsl_pkg::CMD_MUL_FD: begin mul_a = {1'b0, fric_q};      mul_b = VW'(dt_q); end
      dmsl_pkg::CMD_SQ_X:   begin mul_a = dmsl_pkg::mag(tx);   mul_b = dmsl_pkg::mag(tx); end
      dmsl_pkg::CMD_SQ_Y:   begin mul_a = dmsl_pkg::mag(ty);   mul_b = dmsl_pkg::mag(ty); end
      dmsl_pkg::CMD_LIM_SQ: begin mul_a = lim;                 mul_b = lim; end
      dmsl_pkg::CMD_DMUL_X: begin mul_a = dmsl_pkg::mag(tx);   mul_b = num_q; end
      dmsl_pkg::CMD_DMUL_Y: begin mul_a = dmsl_pkg::mag(ty);   mul_b = num_q; end
      dmsl_pkg::CMD_MUL_PX: begin mul_a = dmsl_pkg::mag(vx_q); mul_b = VW'(dt_q); end
      dmsl_pkg::CMD_MUL_PY: begin mul_a = dmsl_pkg::mag(vy_q); mul_b = VW'(dt_q); end
      default: ;
    endcase
  end

  assign step_ext  = $signed({2'b00, mul_q[PW-1:0]});
  assign pos_round = {1'b0, mul_q[PW-1:0]} + (PW+1)'(1 << (dmsl_pkg::POS_SHIFT - 1));
  assign pos_ext   = $signed(SW'(pos_round[PW:dmsl_pkg::POS_SHIFT]));

  assign iter_go   = (cmd_i.op == dmsl_pkg::CMD_SQRT_GO) || (cmd_i.op == dmsl_pkg::CMD_DIV_GO);
  assign iter_mode = (cmd_i.op == dmsl_pkg::CMD_SQRT_GO) ? dmsl_pkg::IT_SQRT : dmsl_pkg::IT_DIV;

  dmsl_iter u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (iter_go),
    .mode_i  (iter_mode),
    .src_i   ((cmd_i.op == dmsl_pkg::CMD_SQRT_GO) ? acc_q : mul_q),
    .den_i   (m_q),
    .done_o  (iter_done),
    .res_o   (iter_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0; py_q <= '0; vx_q <= '0; vy_q <= '0; ax_q <= '0; ay_q <= '0;
      max_speed_q <= '0; max_accel_q <= '0; fric_q <= '0;
      dt_q <= '0; fd_q <= '0; mul_q <= '0; acc_q <= '0; m_q <= '0; num_q <= '0;
      stopped_q <= 1'b0; capped_q <= 1'b0;
      out_px_q <= '0; out_py_q <= '0; out_vx_q <= '0; out_vy_q <= '0;
      out_stop_q <= 1'b0; out_cap_q <= 1'b0;
    end else begin
      mul_q <= mul_a * mul_b;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dmsl_pkg::REG_MAX_SPEED: max_speed_q <= cfg_data_i;
          dmsl_pkg::REG_MAX_ACCEL: max_accel_q <= cfg_data_i;
          dmsl_pkg::REG_FRICTION:  fric_q      <= cfg_data_i;
          default: ;
        endcase
      end
      case (cmd_i.op)
        dmsl_pkg::CMD_LATCH: begin
          stopped_q <= 1'b0;
          capped_q  <= 1'b0;
          if (req_type_i) begin
            px_q <= vec_x_i;
            py_q <= vec_y_i;
            vx_q <= '0;
            vy_q <= '0;
          end else begin
            dt_q <= delta_ms_i;
            if (accel_load_i) begin
              ax_q <= vec_x_i;
              ay_q <= vec_y_i;
            end
          end
        end
        dmsl_pkg::CMD_ADD_VX:
          vx_q <= dmsl_pkg::sat(SW'(vx_q) + (ax_q[VW-1] ? -step_ext : step_ext));
        dmsl_pkg::CMD_ADD_VY:
          vy_q <= dmsl_pkg::sat(SW'(vy_q) + (ay_q[VW-1] ? -step_ext : step_ext));
        dmsl_pkg::CMD_SAVE_FD: fd_q <= mul_q[dmsl_pkg::FDW-1:0];
        dmsl_pkg::CMD_SQ_Y:    acc_q <= mul_q;
        dmsl_pkg::CMD_NORM:    acc_q <= acc_q + mul_q;
        dmsl_pkg::CMD_STOP: begin
          vx_q <= '0;
          vy_q <= '0;
          stopped_q <= 1'b1;
        end
        dmsl_pkg::CMD_SET_CAP: capped_q <= 1'b1;
        dmsl_pkg::CMD_SAVE_M: begin
          m_q <= iter_res;
          if (cmd_i.phase == dmsl_pkg::PH_FRIC) begin
            num_q <= (iter_res > fd_q[VW-1:0]) ? VW'(iter_res - fd_q[VW-1:0]) : '0;
          end else begin
            num_q <= lim;
          end
        end
        dmsl_pkg::CMD_WR_X: begin
          if (cmd_i.phase == dmsl_pkg::PH_ACCEL) ax_q <= dmsl_pkg::with_sign(ax_q[VW-1], iter_res);
          else vx_q <= dmsl_pkg::with_sign(vx_q[VW-1], iter_res);
        end
        dmsl_pkg::CMD_WR_Y: begin
          if (cmd_i.phase == dmsl_pkg::PH_ACCEL) ay_q <= dmsl_pkg::with_sign(ay_q[VW-1], iter_res);
          else vy_q <= dmsl_pkg::with_sign(vy_q[VW-1], iter_res);
        end
        dmsl_pkg::CMD_ADD_PX:
          px_q <= dmsl_pkg::sat(SW'(px_q) + (vx_q[VW-1] ? -pos_ext : pos_ext));
        dmsl_pkg::CMD_ADD_PY:
          py_q <= dmsl_pkg::sat(SW'(py_q) + (vy_q[VW-1] ? -pos_ext : pos_ext));
        dmsl_pkg::CMD_RESULT: begin
          out_px_q   <= px_q;
          out_py_q   <= py_q;
          out_vx_q   <= vx_q;
          out_vy_q   <= vy_q;
          out_stop_q <= stopped_q;
          out_cap_q  <= capped_q;
        end
        default: ;
      endcase
    end
  end

  assign stat_o.gt        = acc_q > mul_q;
  assign stat_o.fd_hi     = |fd_q[dmsl_pkg::FDW-1:VW];
  assign stat_o.iter_done = iter_done;

  assign pos_x_out_o    = out_px_q;
  assign pos_y_out_o    = out_py_q;
  assign vel_x_out_o    = out_vx_q;
  assign vel_y_out_o    = out_vy_q;
  assign stopped_o      = out_stop_q;
  assign speed_capped_o = out_cap_q;

endmodule

// ===== rtl/dmsl_ctrl.sv =====
// Sequencer: walks one step item through velocity update, friction, both clamps
// and position update, issuing one datapath command per cycle. Depends on dmsl_pkg.
module dmsl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                req_type_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  dmsl_pkg::dp_stat_t  stat_i,
  output dmsl_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_MAX, ST_AVX, ST_MAY, ST_AVY, ST_MFD, ST_SFD,
    ST_SQX, ST_SQY, ST_NORM, ST_LIMSQ, ST_TEST, ST_SQRT, ST_SQW, ST_SAVEM,
    ST_MULX, ST_DIVX, ST_DXW, ST_WRX, ST_MULY, ST_DIVY, ST_DYW, ST_WRY,
    ST_MPX, ST_APX, ST_MPY, ST_APY, ST_DONE
  } state_e;

  state_e           state_q;
  dmsl_pkg::phase_e phase_q;
  logic             out_valid_q;
  logic             accept;
  logic             can_out;
  logic             go;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign can_out    = !out_valid_q || out_ready_i;
  assign go         = (phase_q == dmsl_pkg::PH_FRIC) ? (!stat_i.fd_hi && stat_i.gt) : stat_i.gt;

  always_comb begin
    cmd_o.phase = phase_q;
    unique case (state_q)
      ST_IDLE:  cmd_o.op = accept ? dmsl_pkg::CMD_LATCH : dmsl_pkg::CMD_NONE;
      ST_MAX:   cmd_o.op = dmsl_pkg::CMD_MUL_AX;
      ST_AVX:   cmd_o.op = dmsl_pkg::CMD_ADD_VX;
      ST_MAY:   cmd_o.op = dmsl_pkg::CMD_MUL_AY;
      ST_AVY:   cmd_o.op = dmsl_pkg::CMD_ADD_VY;
      ST_MFD:   cmd_o.op = dmsl_pkg::CMD_MUL_FD;
      ST_SFD:   cmd_o.op = dmsl_pkg::CMD_SAVE_FD;
      ST_SQX:   cmd_o.op = dmsl_pkg::CMD_SQ_X;
      ST_SQY:   cmd_o.op = dmsl_pkg::CMD_SQ_Y;
      ST_NORM:  cmd_o.op = dmsl_pkg::CMD_NORM;
      ST_LIMSQ: cmd_o.op = dmsl_pkg::CMD_LIM_SQ;
      ST_TEST: begin
        if (phase_q == dmsl_pkg::PH_FRIC) begin
          cmd_o.op = go ? dmsl_pkg::CMD_NONE : dmsl_pkg::CMD_STOP;
        end else if (phase_q == dmsl_pkg::PH_SPEED) begin
          cmd_o.op = go ? dmsl_pkg::CMD_SET_CAP : dmsl_pkg::CMD_NONE;
        end else begin
          cmd_o.op = dmsl_pkg::CMD_NONE;
        end
      end
      ST_SQRT:  cmd_o.op = dmsl_pkg::CMD_SQRT_GO;
      ST_SAVEM: cmd_o.op = dmsl_pkg::CMD_SAVE_M;
      ST_MULX:  cmd_o.op = dmsl_pkg::CMD_DMUL_X;
      ST_DIVX:  cmd_o.op = dmsl_pkg::CMD_DIV_GO;
      ST_WRX:   cmd_o.op = dmsl_pkg::CMD_WR_X;
      ST_MULY:  cmd_o.op = dmsl_pkg::CMD_DMUL_Y;
      ST_DIVY:  cmd_o.op = dmsl_pkg::CMD_DIV_GO;
      ST_WRY:   cmd_o.op = dmsl_pkg::CMD_WR_Y;
      ST_MPX:   cmd_o.op = dmsl_pkg::CMD_MUL_PX;
      ST_APX:   cmd_o.op = dmsl_pkg::CMD_ADD_PX;
      ST_MPY:   cmd_o.op = dmsl_pkg::CMD_MUL_PY;
      ST_APY:   cmd_o.op = dmsl_pkg::CMD_ADD_PY;
      ST_DONE:  cmd_o.op = can_out ? dmsl_pkg::CMD_RESULT : dmsl_pkg::CMD_NONE;
      default:  cmd_o.op = dmsl_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= dmsl_pkg::PH_FRIC;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            phase_q <= dmsl_pkg::PH_FRIC;
            state_q <= req_type_i ? ST_DONE : ST_MAX;
          end
        end
        ST_MAX:   state_q <= ST_AVX;
        ST_AVX:   state_q <= ST_MAY;
        ST_MAY:   state_q <= ST_AVY;
        ST_AVY:   state_q <= ST_MFD;
        ST_MFD:   state_q <= ST_SFD;
        ST_SFD:   state_q <= ST_SQX;
        ST_SQX:   state_q <= ST_SQY;
        ST_SQY:   state_q <= ST_NORM;
        ST_NORM:  state_q <= ST_LIMSQ;
        ST_LIMSQ: state_q <= ST_TEST;
        ST_TEST, ST_WRY: begin
          if (state_q == ST_TEST && go) begin
            state_q <= ST_SQRT;
          end else if (phase_q == dmsl_pkg::PH_FRIC) begin
            phase_q <= dmsl_pkg::PH_SPEED;
            state_q <= ST_SQX;
          end else if (phase_q == dmsl_pkg::PH_SPEED) begin
            phase_q <= dmsl_pkg::PH_ACCEL;
            state_q <= ST_SQX;
          end else begin
            state_q <= ST_MPX;
          end
        end
        ST_SQRT:  state_q <= ST_SQW;
        ST_SQW:   if (stat_i.iter_done) state_q <= ST_SAVEM;
        ST_SAVEM: state_q <= ST_MULX;
        ST_MULX:  state_q <= ST_DIVX;
        ST_DIVX:  state_q <= ST_DXW;
        ST_DXW:   if (stat_i.iter_done) state_q <= ST_WRX;
        ST_WRX:   state_q <= ST_MULY;
        ST_MULY:  state_q <= ST_DIVY;
        ST_DIVY:  state_q <= ST_DYW;
        ST_DYW:   if (stat_i.iter_done) state_q <= ST_WRY;
        ST_MPX:   state_q <= ST_APX;
        ST_APX:   state_q <= ST_MPY;
        ST_MPY:   state_q <= ST_APY;
        ST_APY:   state_q <= ST_DONE;
        ST_DONE: begin
          if (can_out) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/damped_speed_limited_motion_step.sv =====
// Top level of the damped, speed-limited 2D motion step block.
// Depends on dmsl_pkg, dmsl_ctrl, dmsl_dp (and dmsl_iter below it).
//
//   channel | signals                                   | transfer when
//   --------+-------------------------------------------+--------------------------
//   in      | in_valid_i/in_ready_o, req_type_i .. delta | in_valid_i & in_ready_o
//   out     | out_valid_o/out_ready_i, pos/vel/flags     | out_valid_o & out_ready_i
//   cfg     | cfg_we_i, cfg_idx_i, cfg_data_i            | cfg_we_i
//
// A place item goes from the input transfer straight to the done state, where
// its result is registered once the output is free; a step item waits on the
// shared bit-serial root/divide unit (up to three roots and six quotients per step).
// Reset clears position, velocity, acceleration and limit registers.
// A finished result waits in the output register while the next item is taken;
// a new result is held back until the previous one has been transferred.
module damped_speed_limited_motion_step (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [dmsl_pkg::RW-1:0]  cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     req_type_i,
  input  logic                     accel_load_i,
  input  dmsl_pkg::vec_t           vec_x_i,
  input  dmsl_pkg::vec_t           vec_y_i,
  input  logic [dmsl_pkg::TW-1:0]  delta_ms_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output dmsl_pkg::vec_t           pos_x_out_o,
  output dmsl_pkg::vec_t           pos_y_out_o,
  output dmsl_pkg::vec_t           vel_x_out_o,
  output dmsl_pkg::vec_t           vel_y_out_o,
  output logic                     stopped_o,
  output logic                     speed_capped_o
);

  dmsl_pkg::dp_cmd_t  cmd;
  dmsl_pkg::dp_stat_t stat;

  dmsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (req_type_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dmsl_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .accel_load_i   (accel_load_i),
    .vec_x_i        (vec_x_i),
    .vec_y_i        (vec_y_i),
    .delta_ms_i     (delta_ms_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .pos_x_out_o    (pos_x_out_o),
    .pos_y_out_o    (pos_y_out_o),
    .vel_x_out_o    (vel_x_out_o),
    .vel_y_out_o    (vel_y_out_o),
    .stopped_o      (stopped_o),
    .speed_capped_o (speed_capped_o)
  );

endmodule
